@@ hdl/cobs_enc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// COBS encoder package
// Shared types and constants for the COBS frame encoder.
// ----------------------------------------------------------------------------
package cobs_enc_pkg;

    localparam int unsigned MAX_MESSAGE = 254;
    localparam int unsigned MAX_WRITES  = 4;
    localparam int unsigned WR_IDX_W    = $clog2(MAX_WRITES);
    localparam int unsigned WR_CNT_W    = $clog2(MAX_WRITES + 1);

    localparam logic [7:0] RUN_START = 8'h01;
    localparam logic [7:0] RUN_FULL  = 8'hFF;
    localparam logic [8:0] FRAME_MAX = 9'd256;

    typedef enum logic {
        REG_APPEND_DELIM = 1'b0,
        REG_DELIM_VALUE  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] code_position;
        logic [7:0] run_code;
        logic [8:0] next_position;
        logic [7:0] bytes_taken;
        logic       overflow_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        code_position: 8'd0,
        run_code:      RUN_START,
        next_position: 9'd1,
        bytes_taken:   8'd0,
        overflow_seen: 1'b0
    };

    typedef struct packed {
        logic       append_delimiter;
        logic [7:0] delimiter_value;
    } t_cfg;

    typedef struct packed {
        logic [7:0] write_address;
        logic [7:0] write_byte;
        logic       frame_done;
        logic [8:0] frame_length;
        logic       too_long;
    } t_wr;

endpackage
`default_nettype wire

@@ hdl/cobs_frame_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The writes of an item are first held in a pending store, then moved to the output register.
// Throughput: one item per cycle while each item causes at most one write and the output
// is not stalled; an item with several writes (up to three) holds the input, as there is
// a single write output, until its last write moves out; an item with no write does not hold it.
// Reset: synchronous, active low; clears the encoder state and pending writes and
// restores append_delimiter to 1 and delimiter_value to 0.
// ----------------------------------------------------------------------------
// COBS frame encoder
// Stuffs message bytes into a frame buffer through addressed writes, with an
// optional delimiter and frame length report at the end of each message.
// ----------------------------------------------------------------------------
module cobs_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_has_byte,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_write_address,
    output logic [7:0]  o_write_byte,
    output logic        o_frame_done,
    output logic [8:0]  o_frame_length,
    output logic        o_too_long,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cobs_enc_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_cfg                 r_cfg;
    t_wr                  r_ent [MAX_WRITES];
    t_wr                  n_ent [MAX_WRITES];
    logic [WR_CNT_W-1:0]  r_cnt;
    logic [WR_CNT_W-1:0]  n_cnt;
    logic [WR_IDX_W-1:0]  r_idx;
    logic                 r_ovalid;
    t_wr                  r_out;
    logic                 out_free;
    logic                 move;
    logic                 accept;
    t_reg_idx             reg_sel;

    cobs_enc_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_has_byte       (i_has_byte),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_state          (n_state),
        .o_wr             (n_ent),
        .o_count          (n_cnt)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign move     = (r_cnt != '0) && out_free;
    assign o_stall  = (r_cnt > WR_CNT_W'(1)) || ((r_cnt == WR_CNT_W'(1)) && !out_free);
    assign accept   = i_valid && !o_stall;

    assign reg_sel  = t_reg_idx'(paddr[2]);
    assign pready   = 1'b1;

    always_comb begin
        unique case (reg_sel)
            REG_APPEND_DELIM: prdata = {31'd0, r_cfg.append_delimiter};
            REG_DELIM_VALUE:  prdata = {24'd0, r_cfg.delimiter_value};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.append_delimiter <= 1'b1;
            r_cfg.delimiter_value  <= 8'd0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_APPEND_DELIM: r_cfg.append_delimiter <= pwdata[0];
                REG_DELIM_VALUE:  r_cfg.delimiter_value  <= pwdata[7:0];
                default:          r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= STATE_RESET;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
                r_idx   <= '0;
            end else if (move) begin
                r_cnt <= r_cnt - WR_CNT_W'(1);
                r_idx <= r_idx + WR_IDX_W'(1);
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
        if (move) begin
            r_out <= r_ent[r_idx];
        end
    end

    assign o_valid         = r_ovalid;
    assign o_write_address = r_out.write_address;
    assign o_write_byte    = r_out.write_byte;
    assign o_frame_done    = r_out.frame_done;
    assign o_frame_length  = r_out.frame_length;
    assign o_too_long      = r_out.too_long;

endmodule
`default_nettype wire

@@ hdl/cobs_enc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// COBS encoder step
// Computes the buffer writes and the next encoder state for one input item.
// ----------------------------------------------------------------------------
module cobs_enc_step (
    input  cobs_enc_pkg::t_state                    i_state,
    input  cobs_enc_pkg::t_cfg                      i_cfg,
    input  logic                                    i_has_byte,
    input  logic [7:0]                              i_data_byte,
    input  logic                                    i_end_of_message,
    output cobs_enc_pkg::t_state                    o_state,
    output cobs_enc_pkg::t_wr                       o_wr [cobs_enc_pkg::MAX_WRITES],
    output logic [cobs_enc_pkg::WR_CNT_W-1:0]       o_count
);
    import cobs_enc_pkg::*;

    function automatic t_wr mk_wr(input logic [7:0] addr, input logic [7:0] data,
                                  input logic done, input logic [8:0] len);
        t_wr w;
        w.write_address = addr;
        w.write_byte    = data;
        w.frame_done    = done;
        w.frame_length  = len;
        w.too_long      = 1'b0;
        return w;
    endfunction

    always_comb begin
        t_state                s;
        t_wr                   ent [MAX_WRITES];
        logic [WR_CNT_W-1:0]   cnt;
        logic                  taking;
        logic                  full_end;
        logic [8:0]            stuffed;
        logic [9:0]            len_w;
        logic [8:0]            len;
        logic                  ovf;

        s        = i_state;
        cnt      = '0;
        full_end = 1'b0;
        stuffed  = '0;
        len_w    = '0;
        len      = '0;
        for (int k = 0; k < MAX_WRITES; k++) begin
            ent[k] = '0;
        end

        taking = i_has_byte && (s.bytes_taken < 8'(MAX_MESSAGE));
        if (i_has_byte && !taking) begin
            s.overflow_seen = 1'b1;
        end

        if (taking) begin
            s.bytes_taken = s.bytes_taken + 8'd1;
            if (i_data_byte == 8'h00) begin
                ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.code_position, s.run_code, 1'b0, 9'd0);
                cnt             = cnt + WR_CNT_W'(1);
                s.code_position = s.next_position[7:0];
                s.next_position = s.next_position + 9'd1;
                s.run_code      = RUN_START;
            end else begin
                ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.next_position[7:0], i_data_byte,
                                               1'b0, 9'd0);
                cnt             = cnt + WR_CNT_W'(1);
                s.next_position = s.next_position + 9'd1;
                s.run_code      = s.run_code + 8'd1;
                if (s.run_code == RUN_FULL) begin
                    ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.code_position, s.run_code,
                                                   1'b0, 9'd0);
                    cnt             = cnt + WR_CNT_W'(1);
                    s.code_position = s.next_position[7:0];
                    s.next_position = s.next_position + 9'd1;
                    s.run_code      = RUN_START;
                end
            end
        end

        ovf = s.overflow_seen;

        if (i_end_of_message) begin
            full_end = (s.run_code == RUN_START) &&
                       (s.next_position != ({1'b0, s.bytes_taken} + 9'd1));
            if (full_end) begin
                stuffed = {1'b0, s.code_position};
            end else if (s.next_position > FRAME_MAX) begin
                stuffed = FRAME_MAX;
            end else begin
                stuffed = s.next_position;
            end
            len_w = {1'b0, stuffed} + {9'd0, i_cfg.append_delimiter};
            len   = (len_w > {1'b0, FRAME_MAX}) ? FRAME_MAX : len_w[8:0];

            if (!full_end) begin
                if (i_cfg.append_delimiter) begin
                    ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.code_position, s.run_code,
                                                   1'b0, 9'd0);
                end else begin
                    ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.code_position, s.run_code,
                                                   1'b1, len);
                end
                cnt = cnt + WR_CNT_W'(1);
            end
            if (i_cfg.append_delimiter) begin
                ent[cnt[WR_IDX_W-1:0]] = mk_wr(stuffed[7:0], i_cfg.delimiter_value,
                                               1'b1, len);
                cnt = cnt + WR_CNT_W'(1);
            end else if (full_end) begin
                ent[cnt[WR_IDX_W-1:0]] = mk_wr(s.code_position + 8'd1, RUN_FULL,
                                               1'b1, len);
                cnt = cnt + WR_CNT_W'(1);
            end
            s = STATE_RESET;
        end

        for (int k = 0; k < MAX_WRITES; k++) begin
            ent[k].too_long = ovf;
            o_wr[k]         = ent[k];
        end
        o_state = s;
        o_count = cnt;
    end

endmodule
`default_nettype wire

@@ verif/cobs_frame_encoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder testbench
// Feeds short and long messages with random contents through the encoder
// under several delimiter settings, with random idle bursts on both channels,
// and checks every frame buffer write against a local model of the stuffing.
// ----------------------------------------------------------------------------
module cobs_frame_encoder_test;

    import cobs_enc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AFTER  = 120;

    typedef struct {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_msg_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_has_byte = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_write_address;
    logic [7:0]  o_write_byte;
    logic        o_frame_done;
    logic [8:0]  o_frame_length;
    logic        o_too_long;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_msg_item   msg_items[$];
    t_wr         expected_writes[$];
    t_msg_item   next_item;
    t_wr         want_wr;

    // Encoder model state and register shadow.
    logic [7:0]  enc_code_pos = 8'd0;
    logic [7:0]  enc_run = RUN_START;
    logic [8:0]  enc_next_pos = 9'd1;
    logic [7:0]  enc_taken = 8'd0;
    logic        enc_overflow = 1'b0;
    logic        cfg_append = 1'b1;
    logic [7:0]  cfg_delim = 8'd0;

    logic        gaps_on = 1'b1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned items_taken = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;

    cobs_frame_encoder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_has_byte       (i_has_byte),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_write_address  (o_write_address),
        .o_write_byte     (o_write_byte),
        .o_frame_done     (o_frame_done),
        .o_frame_length   (o_frame_length),
        .o_too_long       (o_too_long),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s mismatch, got %0d expected %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic push_write(input logic [7:0] addr, input logic [7:0] value,
                              input logic done, input logic [8:0] len);
        t_wr w;
        w.write_address = addr;
        w.write_byte    = value;
        w.frame_done    = done;
        w.frame_length  = len;
        w.too_long      = enc_overflow;
        expected_writes.push_back(w);
    endtask

    task automatic close_run();
        push_write(enc_code_pos, enc_run, 1'b0, 9'd0);
        enc_code_pos = enc_next_pos[7:0];
        enc_next_pos = enc_next_pos + 9'd1;
        enc_run      = RUN_START;
    endtask

    task automatic encode_item(input logic has, input logic [7:0] data, input logic eom);
        logic       full_end;
        logic [8:0] stuffed;
        logic [9:0] len;
        if (has) begin
            if (enc_taken >= MAX_MESSAGE) begin
                enc_overflow = 1'b1;
            end else begin
                enc_taken = enc_taken + 8'd1;
                if (data == 8'd0) begin
                    close_run();
                end else begin
                    push_write(enc_next_pos[7:0], data, 1'b0, 9'd0);
                    enc_next_pos = enc_next_pos + 9'd1;
                    enc_run      = enc_run + 8'd1;
                    if (enc_run == RUN_FULL) begin
                        close_run();
                    end
                end
            end
        end
        if (eom) begin
            // A message that ended right after a full block has no trailing code.
            full_end = (enc_run == RUN_START) && (enc_next_pos != {1'b0, enc_taken} + 9'd1);
            if (full_end) begin
                stuffed = {1'b0, enc_code_pos};
            end else begin
                stuffed = (enc_next_pos > FRAME_MAX) ? FRAME_MAX : enc_next_pos;
            end
            len = {1'b0, stuffed} + (cfg_append ? 10'd1 : 10'd0);
            if (len > 10'd256) begin
                len = 10'd256;
            end
            if (!full_end) begin
                push_write(enc_code_pos, enc_run, !cfg_append, cfg_append ? 9'd0 : len[8:0]);
            end
            if (cfg_append) begin
                push_write(stuffed[7:0], cfg_delim, 1'b1, len[8:0]);
            end else if (full_end) begin
                push_write(enc_code_pos + 8'd1, RUN_FULL, 1'b1, len[8:0]);
            end
            enc_code_pos = 8'd0;
            enc_run      = RUN_START;
            enc_next_pos = 9'd1;
            enc_taken    = 8'd0;
            enc_overflow = 1'b0;
        end
    endtask

    // Input channel driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_item(i_has_byte, i_data_byte, i_end_of_message);
                items_taken <= items_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 6) == 0) begin
                    gap_left <= $urandom_range(1, 16) - 1;
                    i_valid  <= 1'b0;
                end else if (msg_items.size() > 0) begin
                    next_item        = msg_items.pop_front();
                    i_valid          <= 1'b1;
                    i_has_byte       <= next_item.has_byte;
                    i_data_byte      <= next_item.data_byte;
                    i_end_of_message <= next_item.end_of_message;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output channel back-pressure, with one long hold that fills the encoder.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && items_taken >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Output channel monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_writes.size() == 0) begin
                report_mismatch("unexpected write, address", o_write_address, 0);
            end else begin
                want_wr = expected_writes.pop_front();
                if (o_write_address !== want_wr.write_address) begin
                    report_mismatch("write_address", o_write_address, want_wr.write_address);
                end
                if (o_write_byte !== want_wr.write_byte) begin
                    report_mismatch("write_byte", o_write_byte, want_wr.write_byte);
                end
                if (o_frame_done !== want_wr.frame_done) begin
                    report_mismatch("frame_done", o_frame_done, want_wr.frame_done);
                end
                if (o_frame_length !== want_wr.frame_length) begin
                    report_mismatch("frame_length", o_frame_length, want_wr.frame_length);
                end
                if (o_too_long !== want_wr.too_long) begin
                    report_mismatch("too_long", o_too_long, want_wr.too_long);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic reg_write_check(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == REG_APPEND_DELIM) ? 32'h1 : 32'hFF;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            report_mismatch("register readback", prdata & mask, value & mask);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic append, input logic [7:0] delim);
        reg_write_check(REG_APPEND_DELIM, {31'd0, append});
        reg_write_check(REG_DELIM_VALUE, {24'd0, delim});
        cfg_append = append;
        cfg_delim  = delim;
    endtask

    task automatic add_item(input logic has, input logic [7:0] data, input logic eom);
        t_msg_item it;
        it.has_byte       = has;
        it.data_byte      = data;
        it.end_of_message = eom;
        msg_items.push_back(it);
    endtask

    // A zero_odds of 0 gives a message without zero bytes.
    task automatic add_message(input int count, input int zero_odds, input bit eom_apart);
        logic [7:0] data;
        for (int i = 0; i < count; i++) begin
            if (zero_odds > 0 && $urandom_range(0, zero_odds - 1) == 0) begin
                data = 8'd0;
            end else begin
                data = 8'($urandom_range(1, 255));
            end
            add_item(1'b1, data, !eom_apart && i == count - 1);
        end
        if (eom_apart || count == 0) begin
            add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic drain();
        while (msg_items.size() != 0 || i_valid || expected_writes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int unsigned filled;
        int unsigned len;
        int unsigned r;
        logic        app_set[6];
        logic [7:0]  delim_set[6];

        app_set   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        delim_set = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        delim_set[3] = 8'($urandom_range(1, 254));
        delim_set[4] = 8'($urandom_range(1, 254));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed messages: empty, lone zero, lone 0xFF, an ignored item,
        // runs of zeros, a separate end mark, and a message ending on zero.
        set_config(1'b1, 8'h00);
        add_item(1'b0, 8'h00, 1'b1);
        add_item(1'b1, 8'h00, 1'b1);
        add_item(1'b1, 8'hFF, 1'b1);
        add_item(1'b0, 8'hFF, 1'b0);
        add_item(1'b1, 8'h01, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'h80, 1'b0);
        add_item(1'b0, 8'hAA, 1'b1);
        add_item(1'b1, 8'h00, 1'b0);
        add_item(1'b1, 8'hFF, 1'b1);
        add_item(1'b1, 8'h7F, 1'b0);
        add_item(1'b1, 8'h55, 1'b0);
        add_item(1'b1, 8'h00, 1'b1);
        add_item(1'b0, 8'h00, 1'b0);
        add_item(1'b1, 8'hFE, 1'b0);
        add_item(1'b0, 8'h00, 1'b1);
        drain();

        // Longest message: a full block at the end, then a dropped byte.
        set_config(1'b0, 8'($urandom_range(0, 255)));
        add_message(255, 0, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                gaps_on = 1'b0;
            end
            set_config(app_set[ph], delim_set[ph]);
            filled = 0;
            while (filled < 3) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    len = (r == 1) ? $urandom_range(9, 16) : $urandom_range(0, 8);
                    r = $urandom_range(0, 1);
                    add_message(len, $urandom_range(2, 6), r[0]);
                    filled += len + ((r[0] || len == 0) ? 1 : 0);
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
